// ----- rtl/serial_hex_flash_command_parser_core_defines.svh -----
// ---------------------------------------------------------------------------
// Serial hex flash command parser: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_HEX_FLASH_COMMAND_PARSER_CORE_DEFINES_SVH
`define SERIAL_HEX_FLASH_COMMAND_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define SHFCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHFCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/shfcp_pkg.sv -----
// ---------------------------------------------------------------------------
// shfcp_pkg
// Types, constants and digit decode for the serial hex flash command parser.
// ---------------------------------------------------------------------------
package shfcp_pkg;

  localparam logic [7:0] CH_G_UP  = 8'h47;
  localparam logic [7:0] CH_G_LO  = 8'h67;
  localparam logic [7:0] CH_W_UP  = 8'h57;
  localparam logic [7:0] CH_W_LO  = 8'h77;
  localparam logic [7:0] CH_N_LO  = 8'h6e;
  localparam logic [7:0] CH_M_LO  = 8'h6d;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] ALPHA_OFS = 8'd55;

  localparam logic [15:0] UNLOCK_ADDR_A = 16'h5555;
  localparam logic [15:0] UNLOCK_ADDR_B = 16'h2aaa;
  localparam logic [7:0]  UNLOCK_DATA_1 = 8'haa;
  localparam logic [7:0]  UNLOCK_DATA_2 = 8'h55;
  localparam logic [7:0]  UNLOCK_DATA_3 = 8'ha0;
  localparam logic [15:0] TEST_ADDR     = 16'hffff;
  localparam logic [7:0]  TEST_DATA     = 8'h67;

  localparam logic [1:0] BEAT_UNLOCK_1 = 2'd0;
  localparam logic [1:0] BEAT_UNLOCK_2 = 2'd1;
  localparam logic [1:0] BEAT_UNLOCK_3 = 2'd2;
  localparam logic [1:0] BEAT_TARGET   = 2'd3;

  localparam logic [2:0] POS_CMD   = 3'd0;
  localparam logic [2:0] POS_SKIP  = 3'd1;
  localparam logic [2:0] POS_AH_HI = 3'd2;
  localparam logic [2:0] POS_AH_LO = 3'd3;
  localparam logic [2:0] POS_AL_HI = 3'd4;
  localparam logic [2:0] POS_AL_LO = 3'd5;
  localparam logic [2:0] POS_D_HI  = 3'd6;
  localparam logic [2:0] POS_D_LO  = 3'd7;

  typedef struct packed {
    logic        valid;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
  } cmd_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return c - CH_ZERO;
    end
    return c - ALPHA_OFS;
  endfunction

endpackage

// ----- rtl/serial_hex_flash_command_parser_core.sv -----
// ---------------------------------------------------------------------------
// serial_hex_flash_command_parser_core
// Parses serial hex command bytes into parallel flash read/write bus cycles.
// ---------------------------------------------------------------------------
// Input channel: one received serial byte per request on in_tdata.
// Output channel: one flash bus cycle per request; out_tuser is 1 for write,
// 0 for read; out_tlast marks the final cycle of a command.
// Commands: g/G + 5 hex digits = 1 read; w/W + 5 address + 2 data digits =
// 4 writes (unlock 5555/AA, 2AAA/55, 5555/A0, then target). n reads FFFF,
// m writes 67 to FFFF. Other command bytes are dropped silently.
// Timing: the final byte of a command loads the command buffer, which then
// loads the output register that drives out_tvalid; following bus cycles
// go out one per cycle while the receiver takes them.
// Input flow: any byte is taken while the one-entry command buffer is free.
// A read command holds it until its single bus cycle loads, a write command
// until its target cycle loads; the input is held off until then.
// Reset clears the parse position and drops any partial or buffered command.
// A stalled receiver holds the output register; the command buffer and then
// the input back up behind it.
// ---------------------------------------------------------------------------
module serial_hex_flash_command_parser_core
  import shfcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] bus_address, [23:16] bus_data
  output logic        out_tuser,  // [0] bus_write
  output logic        out_tlast
);

  cmd_t        cmd_req;
  logic        cmd_ready;
  logic [15:0] bus_address;
  logic [7:0]  bus_data;

  assign in_tready = cmd_ready;

  shfcp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_tvalid && in_tready),
    .rx_byte  (in_tdata),
    .cmd_req  (cmd_req)
  );

  shfcp_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_req   (cmd_req),
    .cmd_ready (cmd_ready),
    .out_vld   (out_tvalid),
    .out_rdy   (out_tready),
    .out_wr    (out_tuser),
    .out_addr  (bus_address),
    .out_data  (bus_data),
    .out_lst   (out_tlast)
  );

  assign out_tdata = {bus_data, bus_address};

endmodule

// ----- rtl/shfcp_parser.sv -----
// ---------------------------------------------------------------------------
// shfcp_parser
// Per-byte command parse; issues one bus command request at command end.
// ---------------------------------------------------------------------------
module shfcp_parser
  import shfcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] rx_byte,
  output cmd_t       cmd_req
);

  logic [2:0]  pos_r, pos_nxt;
  logic        is_wr_r, is_wr_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [7:0]  v;
  logic [7:0]  hi;
  cmd_t        req;

  assign v  = digit_value(rx_byte);
  assign hi = {v[3:0], 4'h0};

  always_comb begin
    pos_nxt   = pos_r;
    is_wr_nxt = is_wr_r;
    addr_nxt  = addr_r;
    acc_nxt   = acc_r;
    req       = '0;
    unique case (pos_r)
      POS_CMD: begin
        if (rx_byte == CH_G_LO || rx_byte == CH_G_UP) begin
          is_wr_nxt = 1'b0;
          pos_nxt   = POS_SKIP;
        end else if (rx_byte == CH_W_LO || rx_byte == CH_W_UP) begin
          is_wr_nxt = 1'b1;
          pos_nxt   = POS_SKIP;
        end else if (rx_byte == CH_N_LO) begin
          req.valid = 1'b1;
          req.addr  = TEST_ADDR;
        end else if (rx_byte == CH_M_LO) begin
          req.valid = 1'b1;
          req.wr    = 1'b1;
          req.addr  = TEST_ADDR;
          req.data  = TEST_DATA;
        end
      end
      POS_SKIP: pos_nxt = POS_AH_HI;
      POS_AH_HI: begin
        acc_nxt = hi;
        pos_nxt = POS_AH_LO;
      end
      POS_AH_LO: begin
        addr_nxt = {acc_r | v, 8'h00};
        pos_nxt  = POS_AL_HI;
      end
      POS_AL_HI: begin
        acc_nxt = hi;
        pos_nxt = POS_AL_LO;
      end
      POS_AL_LO: begin
        addr_nxt = addr_r | {8'h00, acc_r + v};
        if (is_wr_r) begin
          pos_nxt = POS_D_HI;
        end else begin
          pos_nxt   = POS_CMD;
          req.valid = 1'b1;
          req.addr  = addr_nxt;
        end
      end
      POS_D_HI: begin
        acc_nxt = hi;
        pos_nxt = POS_D_LO;
      end
      POS_D_LO: begin
        pos_nxt   = POS_CMD;
        req.valid = 1'b1;
        req.wr    = 1'b1;
        req.addr  = addr_r;
        req.data  = acc_r | v;
      end
      default: pos_nxt = POS_CMD;
    endcase
  end

  always_comb begin
    cmd_req       = req;
    cmd_req.valid = req.valid & byte_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_CMD;
      is_wr_r <= 1'b0;
      addr_r  <= '0;
      acc_r   <= '0;
    end else if (byte_vld) begin
      pos_r   <= pos_nxt;
      is_wr_r <= is_wr_nxt;
      addr_r  <= addr_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

// ----- rtl/shfcp_sequencer.sv -----
// ---------------------------------------------------------------------------
// shfcp_sequencer
// Holds one bus command and plays it out as bus cycles into the output register.
// ---------------------------------------------------------------------------
`include "serial_hex_flash_command_parser_core_defines.svh"

module shfcp_sequencer
  import shfcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd_req,
  output logic        cmd_ready,
  output logic        out_vld,
  input  logic        out_rdy,
  output logic        out_wr,
  output logic [15:0] out_addr,
  output logic [7:0]  out_data,
  output logic        out_lst
);

  logic        cmd_vld_r;
  cmd_t        cmd_r;
  logic [1:0]  beat_r;
  logic        ovld_r;
  logic        owr_r;
  logic [15:0] oaddr_r;
  logic [7:0]  odata_r;
  logic        olst_r;

  logic        load;
  logic        last_beat;
  logic        pop;
  logic [15:0] beat_addr;
  logic [7:0]  beat_data;

  assign load      = cmd_vld_r && (!ovld_r || out_rdy);
  assign last_beat = !cmd_r.wr || (beat_r == BEAT_TARGET);
  assign pop       = load && last_beat;
  assign cmd_ready = !cmd_vld_r || pop;

  always_comb begin
    beat_addr = cmd_r.addr;
    beat_data = cmd_r.data;
    if (cmd_r.wr) begin
      unique case (beat_r)
        BEAT_UNLOCK_1: begin
          beat_addr = UNLOCK_ADDR_A;
          beat_data = UNLOCK_DATA_1;
        end
        BEAT_UNLOCK_2: begin
          beat_addr = UNLOCK_ADDR_B;
          beat_data = UNLOCK_DATA_2;
        end
        BEAT_UNLOCK_3: begin
          beat_addr = UNLOCK_ADDR_A;
          beat_data = UNLOCK_DATA_3;
        end
        default: begin
          beat_addr = cmd_r.addr;
          beat_data = cmd_r.data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
      beat_r    <= BEAT_UNLOCK_1;
    end else begin
      if (cmd_req.valid && cmd_ready) begin
        cmd_vld_r <= 1'b1;
        beat_r    <= BEAT_UNLOCK_1;
      end else if (pop) begin
        cmd_vld_r <= 1'b0;
        beat_r    <= BEAT_UNLOCK_1;
      end else if (load) begin
        beat_r <= beat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_req.valid && cmd_ready) begin
      cmd_r <= cmd_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (!ovld_r || out_rdy) begin
      ovld_r <= cmd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      owr_r   <= cmd_r.wr;
      oaddr_r <= beat_addr;
      odata_r <= cmd_r.wr ? beat_data : 8'h00;
      olst_r  <= last_beat;
    end
  end

  assign out_vld  = ovld_r;
  assign out_wr   = owr_r;
  assign out_addr = oaddr_r;
  assign out_data = odata_r;
  assign out_lst  = olst_r;

  `SHFCP_ASSERT_NOW(a_read_single_beat, cmd_vld_r && !cmd_r.wr, beat_r == BEAT_UNLOCK_1,
    "read command past first beat")
  `SHFCP_ASSERT_NOW(a_req_only_when_ready, cmd_req.valid, cmd_ready,
    "command request while sequencer busy")
  `SHFCP_ASSERT_NEXT(a_write_holds, load && !last_beat, cmd_vld_r,
    "write command dropped before target beat")
  `SHFCP_ASSERT_NEXT(a_load_fills_output, load, ovld_r,
    "bus cycle loaded but output not valid")

endmodule

// ----- sim/shfcp_tb_pkg.sv -----
// ---------------------------------------------------------------------------
// Flash bus cycle scoreboard
// Tracks the command parse state from the accepted serial bytes, queues
// the bus cycles each byte must produce and compares the block's output
// cycles against them in order.
// ---------------------------------------------------------------------------
package shfcp_tb_pkg;
  import shfcp_pkg::*;

  typedef struct {
    bit        wr;
    bit [15:0] addr;
    bit [7:0]  data;
    bit        last;
  } bus_cycle_t;

  class flash_cycle_scoreboard;
    bus_cycle_t cycle_q[$];
    int         errors;
    bit [2:0]   parse_pos;
    bit         write_cmd;
    bit [15:0]  addr_acc;
    bit [7:0]   nibble_acc;

    function new();
      errors     = 0;
      parse_pos  = POS_CMD;
      write_cmd  = 1'b0;
      addr_acc   = '0;
      nibble_acc = '0;
    endfunction

    function int pending();
      return cycle_q.size();
    endfunction

    function void push_cycle(bit wr, bit [15:0] addr, bit [7:0] data, bit last);
      bus_cycle_t bc;
      bc.wr   = wr;
      bc.addr = addr;
      bc.data = data;
      bc.last = last;
      cycle_q.push_back(bc);
    endfunction

    function void push_read(bit [15:0] addr);
      push_cycle(1'b0, addr, 8'h00, 1'b1);
    endfunction

    function void push_program(bit [15:0] addr, bit [7:0] data);
      push_cycle(1'b1, UNLOCK_ADDR_A, UNLOCK_DATA_1, 1'b0);
      push_cycle(1'b1, UNLOCK_ADDR_B, UNLOCK_DATA_2, 1'b0);
      push_cycle(1'b1, UNLOCK_ADDR_A, UNLOCK_DATA_3, 1'b0);
      push_cycle(1'b1, addr, data, 1'b1);
    endfunction

    // one accepted serial byte request
    function void note_byte(bit [7:0] c);
      bit [7:0] v;
      bit [7:0] hi;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        v = c - CH_ZERO;
      end else begin
        v = c - ALPHA_OFS;
      end
      hi = {v[3:0], 4'h0};
      case (parse_pos)
        POS_CMD: begin
          if (c == CH_G_UP || c == CH_G_LO) begin
            write_cmd = 1'b0;
            parse_pos = POS_SKIP;
          end else if (c == CH_W_UP || c == CH_W_LO) begin
            write_cmd = 1'b1;
            parse_pos = POS_SKIP;
          end else if (c == CH_N_LO) begin
            push_read(TEST_ADDR);
          end else if (c == CH_M_LO) begin
            push_program(TEST_ADDR, TEST_DATA);
          end
        end
        POS_SKIP: parse_pos = POS_AH_HI;
        POS_AH_HI: begin
          nibble_acc = hi;
          parse_pos  = POS_AH_LO;
        end
        POS_AH_LO: begin
          addr_acc  = {nibble_acc | v, 8'h00};
          parse_pos = POS_AL_HI;
        end
        POS_AL_HI: begin
          nibble_acc = hi;
          parse_pos  = POS_AL_LO;
        end
        POS_AL_LO: begin
          addr_acc[7:0] = nibble_acc + v;
          if (write_cmd) begin
            parse_pos = POS_D_HI;
          end else begin
            parse_pos = POS_CMD;
            push_read(addr_acc);
          end
        end
        POS_D_HI: begin
          nibble_acc = hi;
          parse_pos  = POS_D_LO;
        end
        default: begin
          parse_pos = POS_CMD;
          push_program(addr_acc, nibble_acc | v);
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_cycle(bit wr, bit [15:0] addr, bit [7:0] data, bit last);
      bus_cycle_t bc;
      if (cycle_q.size() == 0) begin
        report($sformatf("unexpected cycle wr=%0b addr=%h data=%h last=%0b",
                         wr, addr, data, last));
        return;
      end
      bc = cycle_q.pop_front();
      if (wr != bc.wr || addr != bc.addr || data != bc.data || last != bc.last) begin
        report($sformatf("got wr=%0b addr=%h data=%h last=%0b, exp wr=%0b addr=%h data=%h last=%0b",
                         wr, addr, data, last, bc.wr, bc.addr, bc.data, bc.last));
      end
    endtask
  endclass

endpackage

// ----- sim/tb_top.sv -----
// ---------------------------------------------------------------------------
// serial_hex_flash_command_parser_core testbench
// Sends directed then random command byte streams with random idle bursts
// on both channels and checks every flash bus cycle in order.
// ---------------------------------------------------------------------------
module tb_top;
  import shfcp_pkg::*;
  import shfcp_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 450;
  localparam int QUIET_FROM  = 390;
  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  flash_cycle_scoreboard sb = new();
  bit quiet;
  int stall_left;
  int idle_cycles;
  int items_sent;

  serial_hex_flash_command_parser_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (rst_n && !quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_cycle(out_tuser, out_tdata[15:0], out_tdata[23:16], out_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic idle_in();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic send_byte(input bit [7:0] c);
    idle_in();
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(c);
    @(negedge clk);
  endtask

  function automatic bit [7:0] rand_digit();
    string hex_chars;
    hex_chars = "0123456789ABCDEFabcdef";
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
  endfunction

  task automatic send_command();
    bit [7:0] cmd;
    int ndig;
    case ($urandom_range(0, 5))
      0: cmd = CH_G_UP;
      1: cmd = CH_G_LO;
      2: cmd = CH_W_UP;
      3: cmd = CH_W_LO;
      4: cmd = CH_N_LO;
      default: cmd = CH_M_LO;
    endcase
    ndig = (cmd == CH_G_UP || cmd == CH_G_LO) ? 5 :
           (cmd == CH_W_UP || cmd == CH_W_LO) ? 7 : 0;
    send_byte(cmd);
    for (int i = 0; i < ndig; i++) begin
      send_byte(rand_digit());
    end
    items_sent += ndig + 1;
  endtask

  initial begin
    bit [7:0] directed [] = '{8'h00, CH_N_LO, CH_M_LO,
                              CH_G_UP, "0", "F", "F", "f", "f",
                              CH_W_LO, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, "a", "9",
                              CH_W_UP, "1", "z", ":", "9", "A", "@", "/",
                              8'hff};
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    quiet      = 1'b0;
    stall_left = 0;
    items_sent = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      send_byte(directed[i]);
    end
    items_sent = directed.size();

    // hold off until the block has drained
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);

    while (items_sent < ITEM_TARGET) begin
      quiet = (items_sent >= QUIET_FROM);
      if ($urandom_range(0, 4) == 0) begin
        send_byte(8'($urandom_range(0, 255)));
        items_sent++;
      end else begin
        send_command();
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
